// ===== src/bsd_pkg.sv =====
`default_nettype none

package bsd_pkg;

   // Decode phases: which field the engine expects next
   localparam logic [2:0] PH_LEN     = 3'd0;
   localparam logic [2:0] PH_LEN8    = 3'd1;
   localparam logic [2:0] PH_CODE    = 3'd2;
   localparam logic [2:0] PH_LOOK_LO = 3'd3;
   localparam logic [2:0] PH_LOOK_HI = 3'd4;
   localparam logic [2:0] PH_ONCE    = 3'd5;
   localparam logic [2:0] PH_TOGGLE  = 3'd6;
   localparam logic [2:0] PH_RAW     = 3'd7;

   // Special codes of the 5-bit character field
   localparam logic [4:0] CODE_LOOK_LO = 5'd26;
   localparam logic [4:0] CODE_LOOK_HI = 5'd27;
   localparam logic [4:0] CODE_ONCE    = 5'd28;
   localparam logic [4:0] CODE_TOGGLE  = 5'd29;
   localparam logic [4:0] CODE_THIRTY  = 5'd30;
   localparam logic [4:0] CODE_RAW     = 5'd31;
   localparam logic [4:0] LEN_ESCAPE   = 5'd31;

   localparam logic [7:0] UPPER_BASE   = 8'h41;
   localparam logic [7:0] LOWER_OFFSET = 8'd32;

   // Results one byte may produce at most
   localparam logic [1:0] MAX_RESULTS = 2'd3;

   // Queue sizes
   localparam int FRONT_DEPTH = 4;
   localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [7:0] char_code;
      logic       string_last;
      logic       empty_string;
   } rsp_type;

   // Fixed symbol table
   function automatic logic [7:0] sym_lookup(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0:  v = 8'h30;
         4'd1:  v = 8'h31;
         4'd2:  v = 8'h32;
         4'd3:  v = 8'h33;
         4'd4:  v = 8'h34;
         4'd5:  v = 8'h35;
         4'd6:  v = 8'h36;
         4'd7:  v = 8'h37;
         4'd8:  v = 8'h38;
         4'd9:  v = 8'h39;
         4'd10: v = 8'h5f;
         4'd11: v = 8'h20;
         4'd12: v = 8'hff;
         4'd13: v = 8'h80;
         4'd14: v = 8'h22;
         4'd15: v = 8'h7b;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Letter in the given case; no range check on the field
   function automatic logic [7:0] letter(input logic [4:0] t, input logic upper);
      logic [7:0] v;
      v = {3'b000, t} + UPPER_BASE + (upper ? 8'd0 : LOWER_OFFSET);
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/bsd_front.sv =====
`default_nettype none

module bsd_front (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [7:0] push_data,
   output logic            full,
   input  wire logic       pop,
   output logic [7:0]      pop_data,
   output logic            empty
);
   import bsd_pkg::*;

   logic [7:0]             mem_ff [FRONT_DEPTH];
   logic [FRONT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FRONT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FRONT_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   // Byte queue flags and transfers
   assign full     = (count_ff == (FRONT_PTR_W+1)'(FRONT_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_front_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FRONT_PTR_W+1)'(FRONT_DEPTH))
      else $error("byte queue holds more than its depth");
`endif

endmodule

`default_nettype wire

// ===== src/bsd_rsp_queue.sv =====
`default_nettype none

module bsd_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bsd_pkg::rsp_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output bsd_pkg::rsp_type      pop_data,
   output logic                  empty
);
   import bsd_pkg::*;

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   // Result queue flags and transfers
   assign full     = (count_ff == (RSP_PTR_W+1)'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("decode engine wrote a result into a full queue");
`endif

endmodule

`default_nettype wire

// ===== src/bsd_engine.sv =====
`default_nettype none

module bsd_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_empty,
   input  wire logic [7:0]  in_data,
   output logic             in_pop,
   input  wire logic        rsp_full,
   output logic             rsp_push,
   output bsd_pkg::rsp_type rsp_data
);
   import bsd_pkg::*;

   logic [14:0] buf_ff, buf_in;
   logic [3:0]  count_ff, count_in;
   logic [2:0]  phase_ff, phase_in;
   logic        upper_ff, upper_in;
   logic [7:0]  rem_ff, rem_in;
   logic        busy_ff, busy_in;
   logic [1:0]  out_cnt_ff, out_cnt_in;

   logic [3:0]  need;
   logic [7:0]  mask;
   logic [3:0]  shift;
   logic [14:0] shifted;
   logic [7:0]  t;
   logic        avail, can, fire, done, load;
   logic        emit;
   logic [7:0]  ch;
   logic        empty_str;
   logic [7:0]  rem_dec;
   logic [2:0]  dec_phase;
   logic        dec_upper;
   logic [7:0]  dec_rem;

   // Field extraction from the bit buffer
   always_comb begin
      case (phase_ff)
         PH_LEN8, PH_RAW: begin
            need = 4'd8;
            mask = 8'hff;
         end
         PH_LOOK_LO, PH_LOOK_HI: begin
            need = 4'd3;
            mask = 8'h07;
         end
         default: begin
            need = 4'd5;
            mask = 8'h1f;
         end
      endcase
   end

   assign avail   = (count_ff >= need);
   assign shift   = count_ff - need;
   assign shifted = buf_ff >> shift;
   assign t       = shifted[7:0] & mask;
   assign rem_dec = rem_ff - 8'd1;

   // Decode of one field
   always_comb begin
      emit      = 1'b0;
      ch        = 8'd0;
      empty_str = 1'b0;
      dec_phase = phase_ff;
      dec_upper = upper_ff;
      dec_rem   = rem_ff;
      case (phase_ff)
         PH_LEN, PH_LEN8: begin
            if (phase_ff == PH_LEN && t[4:0] == LEN_ESCAPE) begin
               dec_phase = PH_LEN8;
            end else if (t == 8'd0) begin
               emit      = 1'b1;
               empty_str = 1'b1;
               dec_phase = PH_LEN;
            end else begin
               dec_rem   = t;
               dec_upper = 1'b0;
               dec_phase = PH_CODE;
            end
         end
         PH_CODE: begin
            if (t[4:0] < CODE_LOOK_LO) begin
               emit = 1'b1;
               ch   = letter(t[4:0], upper_ff);
            end else if (t[4:0] == CODE_LOOK_LO) begin
               dec_phase = PH_LOOK_LO;
            end else if (t[4:0] == CODE_LOOK_HI) begin
               dec_phase = PH_LOOK_HI;
            end else if (t[4:0] == CODE_ONCE) begin
               dec_phase = PH_ONCE;
            end else if (t[4:0] == CODE_TOGGLE) begin
               dec_phase = PH_TOGGLE;
            end else if (t[4:0] == CODE_THIRTY) begin
               emit = 1'b1;
               ch   = {3'b000, CODE_THIRTY};
            end else begin
               dec_phase = PH_RAW;
            end
         end
         PH_LOOK_LO: begin
            emit = 1'b1;
            ch   = sym_lookup({1'b0, t[2:0]});
         end
         PH_LOOK_HI: begin
            emit = 1'b1;
            ch   = sym_lookup({1'b1, t[2:0]});
         end
         PH_ONCE: begin
            emit = 1'b1;
            ch   = letter(t[4:0], ~upper_ff);
         end
         PH_TOGGLE: begin
            emit      = 1'b1;
            dec_upper = ~upper_ff;
            ch        = letter(t[4:0], ~upper_ff);
         end
         default: begin
            emit = 1'b1;
            ch   = t;
         end
      endcase
      // A character ends the string when the count runs out
      if (emit && !empty_str) begin
         dec_rem   = rem_dec;
         dec_phase = (rem_dec == 8'd0) ? PH_LEN : PH_CODE;
      end
   end

   assign rsp_data.char_code    = ch;
   assign rsp_data.string_last  = empty_str || (rem_dec == 8'd0);
   assign rsp_data.empty_string = empty_str;

   // Step control: one field a cycle unless a result meets a full queue; at most three results per byte
   assign can      = (out_cnt_ff != MAX_RESULTS) && avail;
   assign fire     = busy_ff && can && (!emit || !rsp_full);
   assign done     = busy_ff && !can;
   assign load     = (!busy_ff || done) && !in_empty;
   assign in_pop   = load;
   assign rsp_push = fire && emit;

   always_comb begin
      buf_in     = buf_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      upper_in   = upper_ff;
      rem_in     = rem_ff;
      out_cnt_in = out_cnt_ff;
      busy_in    = busy_ff;
      if (load) begin
         buf_in     = {buf_ff[6:0], in_data};
         count_in   = (count_ff > 4'd7) ? 4'd15 : count_ff + 4'd8;
         out_cnt_in = 2'd0;
         busy_in    = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         count_in   = shift;
         phase_in   = dec_phase;
         upper_in   = dec_upper;
         rem_in     = dec_rem;
         out_cnt_in = out_cnt_ff + {1'b0, emit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff     <= '0;
         count_ff   <= '0;
         phase_ff   <= PH_LEN;
         upper_ff   <= 1'b0;
         rem_ff     <= '0;
         out_cnt_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         buf_ff     <= buf_in;
         count_ff   <= count_in;
         phase_ff   <= phase_in;
         upper_ff   <= upper_in;
         rem_ff     <= rem_in;
         out_cnt_ff <= out_cnt_in;
         busy_ff    <= busy_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cap_ends_byte: assert property (@(posedge clock) disable iff (reset)
      busy_ff && out_cnt_ff == MAX_RESULTS && in_empty |=> !busy_ff)
      else $error("engine kept working after three results");
   a_empty_string_form: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_data.empty_string |->
         rsp_data.string_last && rsp_data.char_code == 8'd0)
      else $error("empty string result malformed");
   a_start_after_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(in_pop))
      else $error("engine started without taking a byte");
`endif

endmodule

`default_nettype wire

// ===== src/bitpacked_string_decoder.sv =====
// Bit-packed string decoder.
// Input channel: a queue-like port. A byte of the packed stream is
// transferred on a rising edge with push high and full low; bytes are read
// most significant bit first as one continuous bit stream.
// Result channel: also queue-like. While empty is low the oldest decoded
// character sits on rsp_char_code / rsp_string_last / rsp_empty_string and
// is transferred on a rising edge with pop high.
// A result is visible once the byte that completes it has moved from the
// byte queue into the engine's bit buffer and been decoded into the result
// queue. The decode engine loads a byte, then completes its fields (length,
// code, index or raw byte) one at a time, and takes the next byte only
// after the current one; a four-entry byte queue in front absorbs bursts.
// A byte yields at most three results; leftover bits wait for the next byte.
// Reset (synchronous, active high) empties both queues and returns the
// decoder to expecting a string length with an empty bit buffer.
// When the receiver stalls, the four-entry result queue fills, the engine
// holds on its next character and full rises once the byte queue fills.
`default_nettype none

module bitpacked_string_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_packed_byte,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_char_code,
   output logic            rsp_string_last,
   output logic            rsp_empty_string
);
   import bsd_pkg::*;

   logic       in_empty;
   logic [7:0] in_data;
   logic       in_pop;
   logic       rsp_full;
   logic       rsp_push;
   rsp_type    rsp_wdata;
   rsp_type    rsp_rdata;

   // Front: byte queue
   bsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_packed_byte),
      .full      (full),
      .pop       (in_pop),
      .pop_data  (in_data),
      .empty     (in_empty)
   );

   // Back: field decode engine
   bsd_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_empty (in_empty),
      .in_data  (in_data),
      .in_pop   (in_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_data (rsp_wdata)
   );

   // Result queue
   bsd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wdata),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_rdata),
      .empty     (empty)
   );

   assign rsp_char_code    = rsp_rdata.char_code;
   assign rsp_string_last  = rsp_rdata.string_last;
   assign rsp_empty_string = rsp_rdata.empty_string;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bsd_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_WAIT      = 13;
   localparam int STRING_BYTES  = 170;
   localparam int NOISE_BYTES   = 20;

   typedef struct packed {
      logic [7:0] data;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   localparam rsp_type NO_RSP    = '0;
   localparam rsp_type EMPTY_RSP = {8'h00, 1'b1, 1'b1};

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       push            = 1'b0;
   logic [7:0] req_packed_byte = 8'h00;
   logic       pop             = 1'b0;
   logic       full;
   logic       empty;
   logic [7:0] rsp_char_code;
   logic       rsp_string_last;
   logic       rsp_empty_string;

   bitpacked_string_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_packed_byte  (req_packed_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_char_code    (rsp_char_code),
      .rsp_string_last  (rsp_string_last),
      .rsp_empty_string (rsp_empty_string)
   );

   always #HALF_PERIOD clock = ~clock;

   // Directed stream: 120 bits, ends on a byte and string boundary.
   // Three empty strings, "az" plus code 30, escaped empty string, then an
   // escaped six-character string using both lookups, one-shot case, two
   // toggles (letter field 31 in both cases) and a raw byte.
   stim_row_type directed_rows [15] = '{
      {8'h00, 1'b1, EMPTY_RSP},                  // empty string after reset
      {8'h00, 1'b0, NO_RSP},                     // two more empty strings
      {8'h30, 1'b0, NO_RSP},                     // length 3, no char yet
      {8'h67, 1'b0, NO_RSP},                     // 'a', 'z'
      {8'hDF, 1'b1, {3'b000, CODE_THIRTY}, 1'b1, 1'b0}, // code 30, last
      {8'h00, 1'b1, EMPTY_RSP},                  // escaped length of zero
      {8'hF8, 1'b0, NO_RSP},                     // length escape
      {8'h36, 1'b0, NO_RSP},                     // 8-bit length 6
      {8'h86, 1'b0, NO_RSP},                     // low table entry 0
      {8'hFF, 1'b0, NO_RSP},                     // high table entry 7
      {8'h3F, 1'b0, NO_RSP},                     // one-shot upper, field 31
      {8'hD0, 1'b0, NO_RSP},                     // toggle
      {8'h77, 1'b0, NO_RSP},                     // 'A', toggle again
      {8'hFF, 1'b1, 8'h80, 1'b0, 1'b0},          // lower, field 31: top sum
      {8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0}           // raw 0xff, last
   };

   logic [7:0] symbol_rom [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h5f, 8'h20, 8'hff, 8'h80, 8'h22, 8'h7b
   };

   // Decoder shadow state
   logic [14:0] pend_buf   = '0;
   logic [3:0]  pend_cnt   = '0;
   logic [2:0]  dec_phase  = PH_LEN;
   logic        upper_mode = 1'b0;
   logic [7:0]  chars_left = '0;

   rsp_type    fresh_chars[$];
   rsp_type    pending_chars[$];
   logic [7:0] stream_bytes[$];
   logic [7:0] gen_acc = '0;
   int         gen_cnt = 0;
   int         req_calm = 0;
   int         rsp_calm = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR t=%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Idle cycles before a transfer; now and then a calm stretch of none
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 20);
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic int field_bits(input logic [2:0] ph);
      case (ph)
         PH_LEN8, PH_RAW:        return 8;
         PH_LOOK_LO, PH_LOOK_HI: return 3;
         default:                return 5;
      endcase
   endfunction

   function automatic logic [7:0] case_letter(input logic [4:0] t, input logic upper);
      return (upper ? 8'h41 : 8'h61) + {3'b000, t};
   endfunction

   task automatic emit_char(input logic [7:0] ch);
      rsp_type r;
      chars_left = chars_left - 8'd1;
      r.char_code = ch;
      r.string_last = (chars_left == 8'd0);
      r.empty_string = 1'b0;
      fresh_chars.push_back(r);
      dec_phase = (chars_left == 8'd0) ? PH_LEN : PH_CODE;
   endtask

   task automatic open_string(input logic [7:0] len);
      if (len == 8'd0) begin
         fresh_chars.push_back(EMPTY_RSP);
         dec_phase = PH_LEN;
      end else begin
         chars_left = len;
         upper_mode = 1'b0;
         dec_phase = PH_CODE;
      end
   endtask

   // Characters completed by one packed byte, left in fresh_chars
   task automatic decode_packed_byte(input logic [7:0] b);
      int w;
      int sh;
      logic [7:0] fld;
      fresh_chars.delete();
      pend_buf = {pend_buf[6:0], b};
      pend_cnt = (pend_cnt > 4'd7) ? 4'd15 : pend_cnt + 4'd8;
      w = field_bits(dec_phase);
      while (fresh_chars.size() < 3 && int'(pend_cnt) >= w) begin
         sh = int'(pend_cnt) - w;
         fld = 8'((int'(pend_buf) >> sh) & ((1 << w) - 1));
         pend_cnt = 4'(sh);
         case (dec_phase)
            PH_LEN: begin
               if (fld[4:0] == LEN_ESCAPE) dec_phase = PH_LEN8;
               else open_string(fld);
            end
            PH_LEN8: open_string(fld);
            PH_CODE: begin
               case (fld[4:0])
                  CODE_LOOK_LO: dec_phase = PH_LOOK_LO;
                  CODE_LOOK_HI: dec_phase = PH_LOOK_HI;
                  CODE_ONCE:    dec_phase = PH_ONCE;
                  CODE_TOGGLE:  dec_phase = PH_TOGGLE;
                  CODE_THIRTY:  emit_char(fld);
                  CODE_RAW:     dec_phase = PH_RAW;
                  default:      emit_char(case_letter(fld[4:0], upper_mode));
               endcase
            end
            PH_LOOK_LO: emit_char(symbol_rom[{1'b0, fld[2:0]}]);
            PH_LOOK_HI: emit_char(symbol_rom[{1'b1, fld[2:0]}]);
            PH_ONCE:    emit_char(case_letter(fld[4:0], !upper_mode));
            PH_TOGGLE: begin
               upper_mode = !upper_mode;
               emit_char(case_letter(fld[4:0], upper_mode));
            end
            default:    emit_char(fld);
         endcase
         w = field_bits(dec_phase);
      end
   endtask

   // Bit packer for the random stream, MSB first
   task automatic put_bits(input int value, input int nbits);
      for (int i = nbits - 1; i >= 0; i--) begin
         gen_acc = {gen_acc[6:0], value[i]};
         gen_cnt++;
         if (gen_cnt == 8) begin
            stream_bytes.push_back(gen_acc);
            gen_cnt = 0;
         end
      end
   endtask

   // Well-formed strings with random content, then raw noise bytes
   task automatic build_random_stream();
      int kind;
      int len;
      int code;
      logic escaped;
      while (stream_bytes.size() < STRING_BYTES) begin
         kind = $urandom_range(0, 19);
         escaped = 1'b0;
         if (kind == 0) begin
            escaped = 1'b1;
            len = 0;
         end else if (kind <= 2) begin
            escaped = 1'b1;
            len = $urandom_range(1, 48);
         end else if (kind == 3) begin
            len = 0;
         end else if (kind == 4) begin
            len = 30;
         end else begin
            len = $urandom_range(1, 6);
         end
         if (escaped) begin
            put_bits(LEN_ESCAPE, 5);
            put_bits(len, 8);
         end else begin
            put_bits(len, 5);
         end
         repeat (len) begin
            code = $urandom_range(0, 31);
            put_bits(code, 5);
            if (code == CODE_LOOK_LO || code == CODE_LOOK_HI)
               put_bits($urandom_range(0, 7), 3);
            else if (code == CODE_ONCE || code == CODE_TOGGLE)
               put_bits($urandom_range(0, 31), 5);
            else if (code == CODE_RAW)
               put_bits($urandom_range(0, 255), 8);
         end
      end
      if (gen_cnt != 0) put_bits($urandom_range(0, 255), 8 - gen_cnt);
      repeat (NOISE_BYTES) stream_bytes.push_back(8'($urandom));
   endtask

   // One input transfer; push stays high across back-to-back bytes
   task automatic transfer_byte(input logic [7:0] b, input logic typed,
                                input rsp_type want);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_packed_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      decode_packed_byte(b);
      if (typed) pending_chars.push_back(want);
      else foreach (fresh_chars[i]) pending_chars.push_back(fresh_chars[i]);
   endtask

   task automatic check_char(input rsp_type got);
      rsp_type want;
      if (pending_chars.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: char %h last %b empty %b",
                                   got.char_code, got.string_last, got.empty_string));
         return;
      end
      want = pending_chars.pop_front();
      if (got.char_code !== want.char_code)
         report_mismatch($sformatf("char_code %h, expected %h",
                                   got.char_code, want.char_code));
      if (got.string_last !== want.string_last)
         report_mismatch($sformatf("string_last %b, expected %b (char %h)",
                                   got.string_last, want.string_last, want.char_code));
      if (got.empty_string !== want.empty_string)
         report_mismatch($sformatf("empty_string %b, expected %b (char %h)",
                                   got.empty_string, want.empty_string, want.char_code));
   endtask

   // Stimulus and end of run
   initial begin
      build_random_stream();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         transfer_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      foreach (stream_bytes[i])
         transfer_byte(stream_bytes[i], 1'b0, NO_RSP);
      push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      // let any stray result surface
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("PASS bitpacked_string_decoder");
      else $display("FAIL bitpacked_string_decoder");
      $finish;
   end

   // Result side: random stalls, check each transfer
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_wait(rsp_calm);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         check_char({rsp_char_code, rsp_string_last, rsp_empty_string});
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL bitpacked_string_decoder");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
src/bsd_pkg.sv
src/bsd_front.sv
src/bsd_rsp_queue.sv
src/bsd_engine.sv
src/bitpacked_string_decoder.sv
tb/tb_top.sv
